[src/unique_value_deque_top_assert.svh]
// ----------------------------------------------------------------------------
// unique_value_deque_top_assert.svh
// Assertion macros shared by the deque sequencer and its top level.
// ----------------------------------------------------------------------------
`ifndef UNIQUE_VALUE_DEQUE_TOP_ASSERT_SVH
`define UNIQUE_VALUE_DEQUE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define UDQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("udq: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define UDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("udq: next-cycle check failed");

`endif

[src/udq_pkg.sv]
// ----------------------------------------------------------------------------
// udq_pkg
// Types, command codes and status codes of the unique value deque.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package udq_pkg;

    localparam int DATA_W    = 32;
    localparam int DEPTH_DEF = 16;

    localparam logic [2:0] CMD_PUSH_TOP = 3'd0;
    localparam logic [2:0] CMD_PUSH_BOT = 3'd1;
    localparam logic [2:0] CMD_POP_TOP  = 3'd2;
    localparam logic [2:0] CMD_POP_BOT  = 3'd3;
    localparam logic [2:0] CMD_REMOVE   = 3'd4;
    localparam logic [2:0] CMD_CLEAR    = 3'd5;
    localparam logic [2:0] CMD_PROBE    = 3'd6;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_DUP  = 2'd1,
        ST_MISS = 2'd2,
        ST_FULL = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]               cmd;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] top_value;
        logic signed [DATA_W-1:0] bottom_value;
        logic [4:0]               entry_count;
        logic                     is_empty;
        logic                     found;
    } t_out_item;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } t_seq_stat;

endpackage

[src/unique_value_deque_top.sv]
// ----------------------------------------------------------------------------
// unique_value_deque_top
// Double-ended queue of distinct signed values with duplicate rejection.
//
//   channel   dir   handshake                  payload
//   input     in    i_in_valid / o_in_ready    i_in_item  (cmd, value)
//   result    out   o_out_valid / i_out_ready  o_out_item (status .. found)
//
// Work per item, N entries held, entry found at position p:
//   pop, clear, unused code: go straight to execution, no membership scan.
//   push, probe: each held entry costs one read of the store read port
//   during the membership scan.
//   remove: the scan stops at the match, then compaction moves the N - p - 1
//   later entries one per cycle through the store read and write ports.
// Reset (i_rst_n low, synchronous) empties the queue at once; no clearing pass.
// A stalled result waits in the output register while the next item transfers
// in; the sequencer then holds its own result until that register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "unique_value_deque_top_assert.svh"

module unique_value_deque_top import udq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_seq_stat         w_stat;
    t_out_item         w_result;
    logic              w_start;
    logic              w_take;
    logic              w_rd_en;
    logic [IW-1:0]     w_rd_addr;
    logic [DATA_W-1:0] w_rd_data;
    logic              w_wr_en;
    logic [IW-1:0]     w_wr_addr;
    logic [DATA_W-1:0] w_wr_data;

    logic              r_out_valid;
    t_out_item         r_out_item;

    // take a new item whenever the sequencer is idle
    assign o_in_ready = w_stat.idle;
    assign w_start    = i_in_valid && o_in_ready;

    // move a finished result into the output register when it is empty or draining
    assign w_take = w_stat.res_valid && (!r_out_valid || i_out_ready);

    udq_seq #(
        .DEPTH (DEPTH),
        .IW    (IW),
        .CW    (CW)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_item    (i_in_item),
        .i_take    (w_take),
        .o_stat    (w_stat),
        .o_result  (w_result),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data)
    );

    udq_store #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    // output register: hold the result until the consumer takes the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `UDQ_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_start, !o_in_ready)
    `UDQ_ASSERT_NEXT(a_result_kept, i_clk, i_rst_n, w_stat.res_valid && !w_take, w_stat.res_valid)

endmodule

[src/udq_store.sv]
// ----------------------------------------------------------------------------
// udq_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module udq_store import udq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    parameter int IW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [IW-1:0]     i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [IW-1:0]     i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // hold read data between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/udq_seq.sv]
// ----------------------------------------------------------------------------
// udq_seq
// Sequencer: scans, writes and compacts the store one entry per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "unique_value_deque_top_assert.svh"

module udq_seq import udq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    parameter int IW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_in_item          i_item,
    input  logic              i_take,
    output t_seq_stat         o_stat,
    output t_out_item         o_result,
    output logic              o_rd_en,
    output logic [IW-1:0]     o_rd_addr,
    input  logic [DATA_W-1:0] i_rd_data,
    output logic              o_wr_en,
    output logic [IW-1:0]     o_wr_addr,
    output logic [DATA_W-1:0] o_wr_data
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_EXEC  = 7'b0000100,
        S_SHIFT = 7'b0001000,
        S_TOP   = 7'b0010000,
        S_BOT   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [IW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_count, n_count;
    logic              r_chk_vld, n_chk_vld;
    logic              r_wvld, n_wvld;
    logic [2:0]        r_cmd, n_cmd;
    logic [DATA_W-1:0] r_value, n_value;
    logic [CW-1:0]     r_ipos, n_ipos;
    logic [IW-1:0]     r_islot, n_islot;
    logic [CW-1:0]     r_chk_pos, n_chk_pos;
    logic [IW-1:0]     r_chk_slot, n_chk_slot;
    logic              r_found, n_found;
    logic [CW-1:0]     r_fpos, n_fpos;
    logic [IW-1:0]     r_fslot, n_fslot;
    logic [IW-1:0]     r_dslot, n_dslot;
    t_status           r_status, n_status;
    logic [DATA_W-1:0] r_top, n_top;
    logic [CW+4:0]     w_cnt_ext;

    function automatic logic [IW-1:0] f_inc(input logic [IW-1:0] s);
        return (s == IW'(DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [IW-1:0] f_dec(input logic [IW-1:0] s);
        return (s == '0) ? IW'(DEPTH - 1) : s - 1'b1;
    endfunction

    // slot of position c counted from slot s, one wrap at most
    function automatic logic [IW-1:0] f_add(input logic [IW-1:0] s, input logic [CW-1:0] c);
        logic [CW:0] sum;
        sum = (CW+1)'(s) + (CW+1)'(c);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_chk_vld  = r_chk_vld;
        n_wvld     = r_wvld;
        n_cmd      = r_cmd;
        n_value    = r_value;
        n_ipos     = r_ipos;
        n_islot    = r_islot;
        n_chk_pos  = r_chk_pos;
        n_chk_slot = r_chk_slot;
        n_found    = r_found;
        n_fpos     = r_fpos;
        n_fslot    = r_fslot;
        n_dslot    = r_dslot;
        n_status   = r_status;
        n_top      = r_top;
        o_rd_en    = 1'b0;
        o_rd_addr  = r_islot;
        o_wr_en    = 1'b0;
        o_wr_addr  = r_dslot;
        o_wr_data  = i_rd_data;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd     = i_item.cmd;
                    n_value   = i_item.value;
                    n_found   = 1'b0;
                    n_status  = ST_DONE;
                    n_ipos    = '0;
                    n_islot   = r_head;
                    n_chk_vld = 1'b0;
                    if (i_item.cmd == CMD_PUSH_TOP || i_item.cmd == CMD_PUSH_BOT ||
                        i_item.cmd == CMD_REMOVE || i_item.cmd == CMD_PROBE) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_SCAN: begin
                // compare last read, issue next read
                if (r_chk_vld && (i_rd_data == r_value)) begin
                    n_found   = 1'b1;
                    n_fpos    = r_chk_pos;
                    n_fslot   = r_chk_slot;
                    n_chk_vld = 1'b0;
                    n_state   = S_EXEC;
                end else if (r_ipos < r_count) begin
                    o_rd_en    = 1'b1;
                    o_rd_addr  = r_islot;
                    n_chk_vld  = 1'b1;
                    n_chk_pos  = r_ipos;
                    n_chk_slot = r_islot;
                    n_ipos     = r_ipos + 1'b1;
                    n_islot    = f_inc(r_islot);
                end else begin
                    n_chk_vld = 1'b0;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_TOP;
                case (r_cmd)
                    CMD_PUSH_TOP, CMD_PUSH_BOT: begin
                        if (r_found) begin
                            n_status = ST_DUP;
                        end else if (r_count == CW'(DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            o_wr_en   = 1'b1;
                            o_wr_data = r_value;
                            n_count   = r_count + 1'b1;
                            if (r_cmd == CMD_PUSH_TOP) begin
                                o_wr_addr = f_dec(r_head);
                                n_head    = f_dec(r_head);
                            end else begin
                                o_wr_addr = f_add(r_head, r_count);
                            end
                        end
                    end
                    CMD_POP_TOP: begin
                        if (r_count == '0) begin
                            n_status = ST_MISS;
                        end else begin
                            n_head  = f_inc(r_head);
                            n_count = r_count - 1'b1;
                        end
                    end
                    CMD_POP_BOT: begin
                        if (r_count == '0) begin
                            n_status = ST_MISS;
                        end else begin
                            n_count = r_count - 1'b1;
                        end
                    end
                    CMD_REMOVE: begin
                        if (!r_found) begin
                            n_status = ST_MISS;
                        end else begin
                            n_ipos  = r_fpos + 1'b1;
                            n_islot = f_inc(r_fslot);
                            n_dslot = r_fslot;
                            n_wvld  = 1'b0;
                            n_state = S_SHIFT;
                        end
                    end
                    CMD_CLEAR: begin
                        n_count = '0;
                        n_head  = '0;
                    end
                    CMD_PROBE: begin
                        n_status = r_found ? ST_DONE : ST_MISS;
                    end
                    default: begin
                    end
                endcase
            end
            S_SHIFT: begin
                // write back the entry read last cycle one slot lower
                if (r_wvld) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_dslot;
                    o_wr_data = i_rd_data;
                    n_dslot   = f_inc(r_dslot);
                end
                if (r_ipos < r_count) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_islot;
                    n_ipos    = r_ipos + 1'b1;
                    n_islot   = f_inc(r_islot);
                    n_wvld    = 1'b1;
                end else begin
                    n_wvld = 1'b0;
                    if (!r_wvld) begin
                        n_count = r_count - 1'b1;
                        n_state = S_TOP;
                    end
                end
            end
            S_TOP: begin
                if (r_count != '0) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_head;
                end
                n_state = S_BOT;
            end
            S_BOT: begin
                n_top = i_rd_data;
                if (r_count != '0) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = f_add(r_head, r_count - 1'b1);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_chk_vld <= 1'b0;
            r_wvld    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_chk_vld <= n_chk_vld;
            r_wvld    <= n_wvld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_value    <= n_value;
        r_ipos     <= n_ipos;
        r_islot    <= n_islot;
        r_chk_pos  <= n_chk_pos;
        r_chk_slot <= n_chk_slot;
        r_found    <= n_found;
        r_fpos     <= n_fpos;
        r_fslot    <= n_fslot;
        r_dslot    <= n_dslot;
        r_status   <= n_status;
        r_top      <= n_top;
    end

    assign w_cnt_ext = {5'b0, r_count};

    assign o_stat.idle      = (r_state == S_IDLE);
    assign o_stat.res_valid = (r_state == S_DONE);

    // read data holds in the done state, so it still carries the bottom entry
    always_comb begin
        o_result.status       = r_status;
        o_result.top_value    = (r_count != '0) ? r_top : '0;
        o_result.bottom_value = (r_count != '0) ? i_rd_data : '0;
        o_result.entry_count  = w_cnt_ext[4:0];
        o_result.is_empty     = (r_count == '0);
        o_result.found        = r_found;
    end

    `UDQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    `UDQ_ASSERT_NOW(a_write_state, i_clk, i_rst_n, o_wr_en, (r_state == S_EXEC) || (r_state == S_SHIFT))
    `UDQ_ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, (r_state != S_EXEC) && (r_state != S_SHIFT), $stable(r_count))

endmodule
